// File: hdl/mhsi_pkg.sv
// ----------------------------------------------------------------------------
// mhsi_pkg
// Shared types, constants and the arctangent table for the magnetometer
// hard/soft-iron correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package mhsi_pkg;

   // Widths fixed by the word formats.
   localparam int SAMPLE_W  = 16;
   localparam int HALF_W    = 15;
   localparam int SUM_W     = 17;
   localparam int DEN_W     = 18;
   localparam int NUM_W     = 40;
   localparam int QUO_W     = 23;
   localparam int CORR_W    = 24;
   localparam int HEAD_W    = 16;
   localparam int CXY_W     = 27;
   localparam int ANG_W     = 21;

   localparam int CORDIC_STEPS_DEF = 16;

   localparam logic signed [ANG_W-1:0]  PI_Q16     = 21'sd205887;
   localparam logic signed [HEAD_W-1:0] HEAD_LIMIT = 16'sd25736;
   localparam logic signed [CORR_W-1:0] CORR_MAX   = 24'sh7FFFFF;
   localparam logic signed [CORR_W-1:0] CORR_MIN   = 24'sh800000;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_PREP   = 10'b00_0000_0010,
      ST_MUL    = 10'b00_0000_0100,
      ST_DSTART = 10'b00_0000_1000,
      ST_DIVW   = 10'b00_0001_0000,
      ST_AXEND  = 10'b00_0010_0000,
      ST_CINIT  = 10'b00_0100_0000,
      ST_CROT   = 10'b00_1000_0000,
      ST_DONE   = 10'b01_0000_0000,
      ST_SPARE  = 10'b10_0000_0000
   } state_type;

   // Divider status towards the sequencer.
   typedef struct packed {
      logic done;
      logic ovf;
   } div_stat_type;

   // round(atan(2^-i) * 2^16).
   function automatic logic [ANG_W-1:0] atan_q16(input logic [4:0] idx);
      logic [ANG_W-1:0] r;
      case (idx)
         5'd0:    r = 21'd51472;
         5'd1:    r = 21'd30386;
         5'd2:    r = 21'd16055;
         5'd3:    r = 21'd8150;
         5'd4:    r = 21'd4091;
         5'd5:    r = 21'd2047;
         5'd6:    r = 21'd1024;
         5'd7:    r = 21'd512;
         5'd8:    r = 21'd256;
         5'd9:    r = 21'd128;
         5'd10:   r = 21'd64;
         5'd11:   r = 21'd32;
         5'd12:   r = 21'd16;
         5'd13:   r = 21'd8;
         5'd14:   r = 21'd4;
         5'd15:   r = 21'd2;
         5'd16:   r = 21'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mag_hard_soft_iron_correct.sv
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_correct
// Min/max hard- and soft-iron magnetometer correction with CORDIC heading.
// ----------------------------------------------------------------------------
// Usage: one raw three-axis sample enters as a word on req_ (x, y, z from the
// lowest bit). The block widens its running per-axis minimum and maximum,
// removes the hard-iron bias, scales each axis by the average half-range over
// its own half-range (4 fraction bits, saturated to 24 bits) and returns the
// heading atan2(y, x) in radians, Q2.13. degenerate on rsp_tuser marks a zero
// half-range; that axis then reads 0. The first sample after reset gives all
// zeros with degenerate set.
// Timing: an accepted word passes through PREP, then for each axis MUL,
// DSTART, DIVW (until the divider is done) and AXEND, then CINIT, the CORDIC
// steps in CROT and DONE, where the result is loaded; an axis with a zero
// half-range skips its division. The next word can be accepted in the cycle
// after the result is loaded. The three divisions run one after the other on a single
// restoring divider at one quotient bit per cycle, and the CORDIC shares one
// rotation stage over its steps. req_tready is high only while the sequencer
// is idle. A finished result sits in the output register until taken; a new
// sample is accepted meanwhile, and if the receiver still stalls when that
// sample completes, the sequencer waits.
// Reset (synchronous) clears the sequencer, the output valid and the
// first-sample flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mag_hard_soft_iron_correct
   import mhsi_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // raw_x, raw_y, raw_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // corr_x, corr_y, corr_z, heading
   output logic             rsp_tuser    // degenerate
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int PROD_W = SAMPLE_W + SUM_W;

   state_type                state_ff, state_in;
   logic                     seen_ff;
   logic [SAMPLE_W-1:0]      max_ff [3];
   logic [SAMPLE_W-1:0]      min_ff [3];
   logic [SAMPLE_W-1:0]      v_ff   [3];
   logic [HALF_W-1:0]        h_ff   [3];
   logic [SAMPLE_W-1:0]      mag_ff [3];
   logic                     neg_ff [3];
   logic signed [CORR_W-1:0] corr_ff [3];
   logic [SUM_W-1:0]         sum_ff;
   logic                     degen_ff;
   logic [1:0]               axis_ff;
   logic [NUM_W-1:0]         n2_ff;
   logic [DEN_W-1:0]         d2_ff;
   logic signed [CXY_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0]  z_ff;
   logic                     zero_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     rsp_valid_ff;
   logic [87:0]              rsp_data_ff;
   logic                     rsp_user_ff;
   logic                     accept;
   logic                     out_free;
   div_stat_type             div_stat;
   logic [QUO_W-1:0]         div_q;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_PREP;
         ST_PREP:   state_in = ST_MUL;
         ST_MUL:    state_in = (h_ff[axis_ff] == '0) ? ST_AXEND : ST_DSTART;
         ST_DSTART: state_in = ST_DIVW;
         ST_DIVW:   if (div_stat.done) state_in = ST_AXEND;
         ST_AXEND:  state_in = (axis_ff == 2'd2) ? ST_CINIT : ST_MUL;
         ST_CINIT:  state_in = ST_CROT;
         ST_CROT:   if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Running extremes, the held sample and the first-sample flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (accept) begin
         seen_ff <= 1'b1;
      end
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            v_ff[k] <= req_tdata[k*SAMPLE_W +: SAMPLE_W];
            if (!seen_ff || req_tdata[k*SAMPLE_W +: SAMPLE_W] > max_ff[k]) begin
               max_ff[k] <= req_tdata[k*SAMPLE_W +: SAMPLE_W];
            end
            if (!seen_ff || req_tdata[k*SAMPLE_W +: SAMPLE_W] < min_ff[k]) begin
               min_ff[k] <= req_tdata[k*SAMPLE_W +: SAMPLE_W];
            end
         end
      end
   end

   // Bias, half-ranges, offsets and their sum.
   always_ff @(posedge clock) begin
      logic [SAMPLE_W:0]        bsum;
      logic signed [SAMPLE_W:0] d;
      logic [HALF_W-1:0]        h;
      logic [SUM_W-1:0]         s;
      logic                     dg;
      if (state_ff == ST_PREP) begin
         s  = '0;
         dg = 1'b0;
         for (int k = 0; k < 3; k++) begin
            h         = HALF_W'((max_ff[k] - min_ff[k]) >> 1);
            bsum      = {1'b0, max_ff[k]} + {1'b0, min_ff[k]};
            d         = $signed({1'b0, v_ff[k]}) - $signed({1'b0, bsum[SAMPLE_W:1]});
            h_ff[k]   <= h;
            neg_ff[k] <= d[SAMPLE_W];
            mag_ff[k] <= d[SAMPLE_W] ? SAMPLE_W'(-d) : SAMPLE_W'(d);
            s         = s + SUM_W'(h);
            dg        = dg || (h == '0);
         end
         sum_ff   <= s;
         degen_ff <= dg;
      end
   end

   // Per-axis numerator and divisor for rounding to nearest.
   always_ff @(posedge clock) begin
      logic [SUM_W-1:0] den;
      if (state_ff == ST_MUL) begin
         den   = SUM_W'(h_ff[axis_ff]) * SUM_W'(3);
         n2_ff <= NUM_W'({PROD_W'(mag_ff[axis_ff]) * PROD_W'(sum_ff), 5'b0})
                  + NUM_W'(den);
         d2_ff <= {den, 1'b0};
      end
   end

   mhsi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DSTART),
      .numer (n2_ff),
      .denom (d2_ff),
      .stat  (div_stat),
      .quot  (div_q)
   );

   // Axis results and axis counter.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         axis_ff <= 2'd0;
      end else if (state_ff == ST_AXEND) begin
         axis_ff <= axis_ff + 2'd1;
      end
      if (state_ff == ST_MUL && h_ff[axis_ff] == '0) begin
         corr_ff[axis_ff] <= '0;
      end else if (state_ff == ST_DIVW && div_stat.done) begin
         if (div_stat.ovf) begin
            corr_ff[axis_ff] <= neg_ff[axis_ff] ? CORR_MIN : CORR_MAX;
         end else begin
            corr_ff[axis_ff] <= neg_ff[axis_ff] ? -$signed({1'b0, div_q})
                                                 :  $signed({1'b0, div_q});
         end
      end
   end

   // CORDIC in vectoring mode, one rotation per cycle.
   always_ff @(posedge clock) begin
      logic signed [CXY_W-1:0] cx, cy, dx, dy;
      logic signed [ANG_W-1:0] at;
      cx = CXY_W'(corr_ff[0]);
      cy = CXY_W'(corr_ff[1]);
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = $signed(atan_q16(5'(step_ff)));
      if (state_ff == ST_CINIT) begin
         zero_ff <= (cx == '0) && (cy == '0);
         step_ff <= '0;
         if (cx < 0) begin
            x_ff <= -cx;
            y_ff <= -cy;
            z_ff <= (cy >= 0) ? PI_Q16 : -PI_Q16;
         end else begin
            x_ff <= cx;
            y_ff <= cy;
            z_ff <= '0;
         end
      end else if (state_ff == ST_CROT) begin
         step_ff <= step_ff + STEP_W'(1);
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      logic signed [ANG_W-1:0]  zr;
      logic signed [HEAD_W-1:0] hd;
      zr = (z_ff + ANG_W'(4)) >>> 3;
      if (zero_ff) begin
         hd = '0;
      end else if (zr > ANG_W'(HEAD_LIMIT)) begin
         hd = HEAD_LIMIT;
      end else if (zr < -ANG_W'(HEAD_LIMIT)) begin
         hd = -HEAD_LIMIT;
      end else begin
         hd = HEAD_W'(zr);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {hd, corr_ff[2], corr_ff[1], corr_ff[0]};
         rsp_user_ff <= degen_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The divider reports only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVW)
      else $error("divider finished outside its wait state");

   // Extremes stay ordered once a sample has been seen.
   a_order: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (max_ff[0] >= min_ff[0]) && (max_ff[1] >= min_ff[1])
                  && (max_ff[2] >= min_ff[2]))
      else $error("axis maximum below minimum");

   // Heading stays within plus or minus pi.
   a_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff[87:72]) <= HEAD_LIMIT)
                       && ($signed(rsp_data_ff[87:72]) >= -HEAD_LIMIT))
      else $error("heading out of range");

endmodule

`default_nettype wire

// File: hdl/mhsi_div.sv
// ----------------------------------------------------------------------------
// mhsi_div
// Restoring divider, one quotient bit per cycle, with an up-front check for
// quotients of 2^23 and above, which the caller saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module mhsi_div
   import mhsi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [DEN_W-1:0]  denom,
   output div_stat_type           stat,
   output logic [QUO_W-1:0]       quot
);

   logic               busy_ff, busy_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   lo_ff, lo_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   div_stat_type       stat_ff, stat_in;
   logic [DEN_W:0]     trial;
   logic               ge;
   logic               ovf;

   // Overflow when the quotient would need more than 23 bits.
   assign ovf   = {1'b0, numer} >= {denom, {QUO_W{1'b0}}};
   assign trial = {rem_ff, lo_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, denom};

   // One subtract-and-compare step per cycle.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      stat_in = '0;
      if (start) begin
         if (ovf) begin
            stat_in.done = 1'b1;
            stat_in.ovf  = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = 5'(QUO_W - 1);
            rem_in  = DEN_W'(numer[NUM_W-1:QUO_W]);
            lo_in   = numer[QUO_W-1:0];
            q_in    = '0;
         end
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, denom}) : DEN_W'(trial);
         lo_in  = {lo_ff[QUO_W-2:0], 1'b0};
         q_in   = {q_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in      = 1'b0;
            stat_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         stat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         stat_ff <= stat_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
   end

   assign stat = stat_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// File: tb/mag_hard_soft_iron_correct_chk.sv
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_correct_chk
// Watches both channels of the magnetometer correction block, predicts each
// result word from the accepted sample words and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module mag_hard_soft_iron_correct_chk
   import mhsi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,   // raw_x, raw_y, raw_z
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [87:0] rsp_tdata,   // corr_x, corr_y, corr_z, heading
   input  wire logic        rsp_tuser,   // degenerate
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        degen;
      logic [15:0] heading;
      logic [23:0] cz;
      logic [23:0] cy;
      logic [23:0] cx;
   } mag_result_t;

   mag_result_t result_fifo[$];
   logic [15:0] run_max[3];
   logic [15:0] run_min[3];
   bit          have_first;

   // Scale one bias-removed axis, rounding half away from zero, then saturate.
   function automatic longint scale_axis(longint d, longint s, longint h);
      longint mag, num, den, q;
      mag = (d < 0) ? -d : d;
      num = mag * s * 16;
      den = 3 * h;
      q   = (2 * num + den) / (2 * den);
      if (d < 0) begin
         q = -q;
      end
      if (q > 8388607) begin
         q = 8388607;
      end
      if (q < -8388608) begin
         q = -8388608;
      end
      return q;
   endfunction

   // Vectoring CORDIC giving atan2(cy, cx) in Q2.13.
   function automatic longint heading_calc(longint cx, longint cy);
      longint x, y, z, dx, dy, r;
      x = cx;
      y = cy;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? 205887 : -205887;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += longint'(atan_q16(5'(i)));
         end else begin
            x -= dx;
            y += dy;
            z -= longint'(atan_q16(5'(i)));
         end
      end
      r = (z + 4) >>> 3;
      if (r > 25736) begin
         r = 25736;
      end
      if (r < -25736) begin
         r = -25736;
      end
      return r;
   endfunction

   // Update the running extremes and work out the corrected word.
   function automatic mag_result_t correct_sample(logic [47:0] w);
      logic [15:0] v[3];
      longint      h[3];
      longint      c[3];
      longint      s, bias;
      mag_result_t r;
      r.degen = 1'b0;
      for (int k = 0; k < 3; k++) begin
         v[k] = w[16*k +: 16];
         if (!have_first) begin
            run_max[k] = v[k];
            run_min[k] = v[k];
         end else begin
            if (v[k] > run_max[k]) run_max[k] = v[k];
            if (v[k] < run_min[k]) run_min[k] = v[k];
         end
      end
      have_first = 1'b1;
      for (int k = 0; k < 3; k++) begin
         h[k] = (longint'(run_max[k]) - longint'(run_min[k])) >> 1;
      end
      s = h[0] + h[1] + h[2];
      for (int k = 0; k < 3; k++) begin
         bias = (longint'(run_max[k]) + longint'(run_min[k])) >> 1;
         if (h[k] == 0) begin
            r.degen = 1'b1;
            c[k] = 0;
         end else begin
            c[k] = scale_axis(longint'(v[k]) - bias, s, h[k]);
         end
      end
      r.cx = c[0][23:0];
      r.cy = c[1][23:0];
      r.cz = c[2][23:0];
      r.heading = 16'(heading_calc(c[0], c[1]));
      return r;
   endfunction

   assign pending = result_fifo.size();

   // Predict on accepted samples, compare on accepted results.
   always @(posedge clock) begin
      mag_result_t got, exp_r;
      if (reset) begin
         have_first = 1'b0;
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            result_fifo.push_back(correct_sample(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (result_fifo.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               fail_count++;
            end else begin
               exp_r = result_fifo.pop_front();
               if (got.cx !== exp_r.cx)
                  $display("%0t: corr_x expected %h actual %h", $time, exp_r.cx, got.cx);
               if (got.cy !== exp_r.cy)
                  $display("%0t: corr_y expected %h actual %h", $time, exp_r.cy, got.cy);
               if (got.cz !== exp_r.cz)
                  $display("%0t: corr_z expected %h actual %h", $time, exp_r.cz, got.cz);
               if (got.heading !== exp_r.heading)
                  $display("%0t: heading expected %h actual %h", $time, exp_r.heading,
                           got.heading);
               if (got.degen !== exp_r.degen)
                  $display("%0t: degenerate expected %b actual %b", $time, exp_r.degen,
                           got.degen);
               if (got !== exp_r) fail_count++;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: tb/mag_hard_soft_iron_correct_tb.sv
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_correct_tb
// Drives directed and random magnetometer samples into the correction block
// with bursty input and a stalling receiver, and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module mag_hard_soft_iron_correct_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // raw_x, raw_y, raw_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // corr_x, corr_y, corr_z, heading
   logic        rsp_tuser;   // degenerate
   int          fail_count;
   int          pending;
   bit          hold_off;

   mag_hard_soft_iron_correct u_top (.*);

   mag_hard_soft_iron_correct_chk u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: allows for about 1150 words plus gaps and stalls, many times over.
   initial begin
      #30ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random stall pattern, with one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= ($urandom_range(0, 2) == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one sample word and wait for it to be taken.
   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_tdata  <= {z, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // A random sample: mostly clustered around a centre, sometimes anywhere.
   task automatic send_random(int centre, int spread);
      logic [15:0] a[3];
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(0, 9) == 0)
            a[k] = 16'($urandom());
         else
            a[k] = 16'(centre + $urandom_range(0, 2 * spread) - spread);
      end
      send_sample(a[0], a[1], a[2]);
   endtask

   initial begin
      int centre, spread, burst;
      hold_off   = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: first sample, degenerate axes, extremes, zero vector, all quadrants.
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8002, 16'h8000, 16'h8000);
      send_sample(16'h8001, 16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h8004, 16'h8000);
      send_sample(16'h8001, 16'h8002, 16'h8000);
      send_sample(16'h8001, 16'h8002, 16'h8006);
      send_sample(16'h0000, 16'hFFFF, 16'h0000);
      send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0000, 16'h1234);
      send_sample(16'h0000, 16'hFFFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF, 16'h5555);
      send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
      req_tvalid <= 1'b0;

      // Long stall of the receiver while words keep coming.
      hold_off = 1'b1;
      repeat (6) send_random(16'h8000, 30000);
      req_tvalid <= 1'b0;
      // Random phases: the extremes are never reset, so the phases vary the
      // spread of samples around a drifting centre instead.
      for (int n = 0; n < 1130; n += burst) begin
         burst = $urandom_range(1, 12);
         if (n % 200 < 12) begin
            centre = $urandom_range(1000, 64000);
            spread = (n % 400 < 12) ? $urandom_range(1, 40) : $urandom_range(100, 30000);
         end
         for (int b = 0; b < burst; b++) send_random(centre, spread);
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 150)) @(negedge clock);
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the block's latency to pass.
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
